### hw/rtl/psfp_pkg.sv
// Package for the PCM sample to float converter with planar placement.
// Holds the field widths, register indexes, reset values and float constants.
// No dependencies; used by psfp_convert and pcm_sample_to_float_planar.
`default_nettype none

package psfp_pkg;

  // Field widths.
  localparam int RawW    = 32;
  localparam int StreamW = 8;
  localparam int SidxW   = 16;
  localparam int DestW   = 25;
  localparam int ChanW   = StreamW + 1;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 16;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_SAMPLE_WIDTH  = 3'd0,
    REG_LITTLE_ENDIAN = 3'd1,
    REG_COUPLED_COUNT = 3'd2,
    REG_STREAM_COUNT  = 3'd3,
    REG_FRAME_SAMPLES = 3'd4
  } cfg_reg_t;

  // Register reset values.
  localparam logic [7:0]  RstSampleWidth  = 8'd16;
  localparam logic        RstLittleEndian = 1'b0;
  localparam logic [7:0]  RstCoupledCount = 8'd0;
  localparam logic [7:0]  RstStreamCount  = 8'd1;
  localparam logic [15:0] RstFrameSamples = 16'd1024;

  // Sample width codes.
  localparam logic [7:0] Width16 = 8'd16;
  localparam logic [7:0] Width24 = 8'd24;
  localparam logic [7:0] Width32 = 8'd32;

  // IEEE single layout.
  localparam int MantBits = 23;
  localparam int ExpBias  = 127;

endpackage

`default_nettype wire

### hw/rtl/pcm_sample_to_float_planar.sv
// Top level: PCM sample to float conversion with planar destination index.
// Depends on psfp_pkg and psfp_convert.
//
//  Channel | Handshake         | Payload
//  in      | in_valid/in_stall | raw_sample, stream_index, channel_side, sample_index
//  out     | out_valid/out_stall | float_bits, dest_index, bad_stream
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One sample is accepted every cycle while in_stall is low; its result is presented
// once it has moved from the input register to the result register.
// The conversion and the stride multiply sit between those two registers.
// Reset is synchronous and clears the valid bits and the configuration.
// While a result is stalled, one further sample is still taken into the
// input register; in_stall rises only once both registers are full.
`default_nettype none

module pcm_sample_to_float_planar (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_raw_sample,
  input  wire logic [7:0]  in_stream_index,
  input  wire logic        in_channel_side,
  input  wire logic [15:0] in_sample_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] out_float_bits,
  output logic      [24:0] out_dest_index,
  output logic             out_bad_stream,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [7:0]  sample_width_r;
  logic        little_endian_r;
  logic [7:0]  coupled_count_r;
  logic [7:0]  stream_count_r;
  logic [15:0] frame_samples_r;

  logic        s1_valid_r;
  logic [31:0] raw_r;
  logic [7:0]  sidx_stream_r;
  logic        side_r;
  logic [15:0] spos_r;

  logic        out_valid_r;
  logic [31:0] float_r;
  logic [24:0] dest_r;
  logic        bad_r;

  logic        advance;
  logic        load_s1;
  logic [31:0] float_nxt;
  logic [8:0]  chan;
  logic        bad_nxt;
  logic [24:0] dest_nxt;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_width_r  <= psfp_pkg::RstSampleWidth;
      little_endian_r <= psfp_pkg::RstLittleEndian;
      coupled_count_r <= psfp_pkg::RstCoupledCount;
      stream_count_r  <= psfp_pkg::RstStreamCount;
      frame_samples_r <= psfp_pkg::RstFrameSamples;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        psfp_pkg::REG_SAMPLE_WIDTH:  sample_width_r  <= cfg_data[7:0];
        psfp_pkg::REG_LITTLE_ENDIAN: little_endian_r <= cfg_data[0];
        psfp_pkg::REG_COUPLED_COUNT: coupled_count_r <= cfg_data[7:0];
        psfp_pkg::REG_STREAM_COUNT:  stream_count_r  <= cfg_data[7:0];
        psfp_pkg::REG_FRAME_SAMPLES: frame_samples_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow control.
  assign advance  = !out_valid_r || !out_stall;
  assign load_s1  = !s1_valid_r || advance;
  assign in_stall = !load_s1;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (load_s1) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_s1 && in_valid) begin
      raw_r         <= in_raw_sample;
      sidx_stream_r <= in_stream_index;
      side_r        <= in_channel_side;
      spos_r        <= in_sample_index;
    end
  end

  // Float conversion.
  psfp_convert u_convert (
    .raw_sample    (raw_r),
    .sample_width  (sample_width_r),
    .little_endian (little_endian_r),
    .float_bits    (float_nxt)
  );

  // Planar destination index.
  always_comb begin
    if (sidx_stream_r < coupled_count_r) begin
      chan = {sidx_stream_r, side_r};
    end else begin
      chan = {1'b0, coupled_count_r} + {1'b0, sidx_stream_r};
    end
    bad_nxt = (sidx_stream_r >= stream_count_r);
    dest_nxt = bad_nxt ? 25'd0
                       : ({9'd0, frame_samples_r} * {16'd0, chan}) + {9'd0, spos_r};
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      float_r <= float_nxt;
      dest_r  <= dest_nxt;
      bad_r   <= bad_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_float_bits = float_r;
  assign out_dest_index = dest_r;
  assign out_bad_stream = bad_r;

  // Checks.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without both registers full");

  a_bad_dest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && bad_r) |-> (dest_r == 25'd0))
    else $error("bad stream with non-zero destination");

  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (float_r[30:0] == 31'd0)) |-> !float_r[31])
    else $error("negative zero produced");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r))
    else $error("valid bits not cleared by reset");

endmodule

`default_nettype wire

### hw/rtl/psfp_convert.sv
// Combinational sample assembly and conversion to IEEE single precision.
// Depends on psfp_pkg for widths and float constants.
`default_nettype none

module psfp_convert (
  input  wire logic [31:0] raw_sample,
  input  wire logic [7:0]  sample_width,
  input  wire logic        little_endian,
  output logic      [31:0] float_bits
);

  logic [7:0]  b0, b1, b2, b3;
  logic        w24, w32, be16;
  logic [15:0] pat16;
  logic [23:0] pat24;
  logic [31:0] pat32;
  logic [31:0] sx;
  logic        neg;
  logic [31:0] mag;
  logic [4:0]  p;
  logic [31:0] norm;
  logic [23:0] keep;
  logic        guard, sticky, rnd;
  logic [24:0] keep_rnd;
  logic        carry;
  logic [7:0]  exp_base;
  logic [7:0]  expo;

  // Byte assembly in the selected order, then sign extension to 32 bits.
  always_comb begin
    b0 = raw_sample[7:0];
    b1 = raw_sample[15:8];
    b2 = raw_sample[23:16];
    b3 = raw_sample[31:24];
    w24 = (sample_width == psfp_pkg::Width24);
    w32 = (sample_width == psfp_pkg::Width32);
    be16 = (sample_width == psfp_pkg::Width16) && !little_endian;
    pat16 = be16 ? {b0, b1} : {b1, b0};
    pat24 = little_endian ? {b2, b1, b0} : {b0, b1, b2};
    pat32 = little_endian ? {b3, b2, b1, b0} : {b0, b1, b2, b3};
    if (w32) begin
      sx = pat32;
      exp_base = 8'(psfp_pkg::ExpBias - 31);
    end else if (w24) begin
      sx = {{8{pat24[23]}}, pat24};
      exp_base = 8'(psfp_pkg::ExpBias - 23);
    end else begin
      sx = {{16{pat16[15]}}, pat16};
      exp_base = 8'(psfp_pkg::ExpBias - 15);
    end
    neg = sx[31];
    mag = neg ? (~sx + 32'd1) : sx;
  end

  // Leading one position of the magnitude.
  always_comb begin
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) begin
        p = 5'(i);
      end
    end
  end

  // Normalise, round to nearest even and pack.
  always_comb begin
    norm = mag << (5'd31 - p);
    keep = norm[31:8];
    guard = norm[7];
    sticky = |norm[6:0];
    rnd = guard && (sticky || keep[0]);
    keep_rnd = {1'b0, keep} + {24'd0, rnd};
    carry = keep_rnd[24];
    expo = exp_base + {3'd0, p} + {7'd0, carry};
    if (mag == 32'd0) begin
      float_bits = 32'd0;
    end else begin
      float_bits = {neg, expo, keep_rnd[psfp_pkg::MantBits-1:0]};
    end
  end

endmodule

`default_nettype wire

### sim/pcm_sample_to_float_planar_tb.sv
// Testbench for pcm_sample_to_float_planar: directed table, then random samples.
// Results are predicted by a local float conversion and planar index model.
// Depends on psfp_pkg and the RTL of the block.
`default_nettype none

module pcm_sample_to_float_planar_tb;
  import psfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] float_bits;
    logic [24:0] dest_index;
    logic        bad_stream;
  } conv_result_t;

  typedef struct {
    logic [31:0] raw;
    logic [7:0]  stream;
    logic        side;
    logic [15:0] sidx;
    logic        has_fixed;
    logic [31:0] fixed_float;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] in_raw_sample = '0;
  logic [7:0]  in_stream_index = '0;
  logic        in_channel_side = 1'b0;
  logic [15:0] in_sample_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_float_bits;
  logic [24:0] out_dest_index;
  logic out_bad_stream;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_reg_t cfg_index = REG_SAMPLE_WIDTH;
  logic [15:0] cfg_data = '0;

  // Local copy of the configuration.
  logic [7:0]  width_q = RstSampleWidth;
  logic        le_q = RstLittleEndian;
  logic [7:0]  coupled_q = RstCoupledCount;
  logic [7:0]  streams_q = RstStreamCount;
  logic [15:0] stride_q = RstFrameSamples;

  conv_result_t pending_results[$];
  int  errors = 0;
  int  cycle_count = 0;
  bit  calm_sender = 1'b0;
  bit  calm_receiver = 1'b0;

  pcm_sample_to_float_planar DUT (.*);

  always #6 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Scale a signed pattern of nbits to an IEEE single, ties to even.
  function automatic logic [31:0] pcm_to_single(logic [31:0] pat, int nbits);
    logic [32:0] mag;
    logic [32:0] keep;
    logic [32:0] rem;
    logic [32:0] half;
    logic neg;
    int msb;
    int expo;
    int sh;
    pat = (nbits == 32) ? pat : (pat & ((32'd1 << nbits) - 1));
    neg = pat[nbits-1];
    mag = neg ? ((33'd1 << nbits) - pat) : {1'b0, pat};
    if (mag == 0) return 32'd0;
    msb = 0;
    for (int i = 0; i < 33; i++) if (mag[i]) msb = i;
    expo = msb + ExpBias - (nbits - 1);
    if (msb <= MantBits) begin
      keep = mag << (MantBits - msb);
    end else begin
      sh = msb - MantBits;
      rem = mag & ((33'd1 << sh) - 1);
      half = 33'd1 << (sh - 1);
      keep = mag >> sh;
      if (rem > half || (rem == half && keep[0])) keep++;
      if (keep[MantBits+1]) begin
        keep = keep >> 1;
        expo++;
      end
    end
    return {neg, expo[7:0], keep[22:0]};
  endfunction

  // Expected result of one sample under the current configuration.
  function automatic conv_result_t predict_sample(logic [31:0] raw, logic [7:0] si,
                                                  logic side, logic [15:0] sidx);
    conv_result_t r;
    logic [7:0] b0, b1, b2, b3;
    logic [31:0] pat;
    logic [31:0] chan;
    int nbits;
    {b3, b2, b1, b0} = raw;
    if (width_q == Width24) begin
      nbits = 24;
      pat = le_q ? {8'd0, b2, b1, b0} : {8'd0, b0, b1, b2};
    end else if (width_q == Width32) begin
      nbits = 32;
      pat = le_q ? {b3, b2, b1, b0} : {b0, b1, b2, b3};
    end else begin
      nbits = 16;
      pat = (width_q == Width16 && !le_q) ? {16'd0, b0, b1} : {16'd0, b1, b0};
    end
    chan = (si < coupled_q) ? 2 * si + side : coupled_q + si;
    r.bad_stream = (si >= streams_q);
    r.dest_index = r.bad_stream ? '0 : 25'(stride_q * chan + sidx);
    r.float_bits = pcm_to_single(pat, nbits);
    return r;
  endfunction

  // One register transfer; the caller drops cfg_valid after the last one.
  task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SAMPLE_WIDTH:  width_q = value[7:0];
      REG_LITTLE_ENDIAN: le_q = value[0];
      REG_COUPLED_COUNT: coupled_q = value[7:0];
      REG_STREAM_COUNT:  streams_q = value[7:0];
      default:           stride_q = value;
    endcase
  endtask

  task automatic set_config(logic [7:0] w, logic le, logic [7:0] cc, logic [7:0] sc,
                            logic [15:0] fs);
    write_reg(REG_SAMPLE_WIDTH, {8'd0, w});
    write_reg(REG_LITTLE_ENDIAN, {15'd0, le});
    write_reg(REG_COUPLED_COUNT, {8'd0, cc});
    write_reg(REG_STREAM_COUNT, {8'd0, sc});
    write_reg(REG_FRAME_SAMPLES, fs);
    cfg_valid <= 1'b0;
  endtask

  // Offer one sample and hold it until the transfer; random gaps first.
  task automatic send_sample(logic [31:0] raw, logic [7:0] si, logic side,
                             logic [15:0] sidx);
    while (!calm_sender && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_sample <= raw;
    in_stream_index <= si;
    in_channel_side <= side;
    in_sample_index <= sidx;
    pending_results.push_back(predict_sample(raw, si, side, sidx));
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver stalls at random unless calm_receiver is set.
  always @(posedge clk) begin
    out_stall <= !calm_receiver && ($urandom_range(99) < 7);
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    conv_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_float_bits !== exp_r.float_bits) begin
          $error("float_bits expected %h got %h", exp_r.float_bits, out_float_bits);
          errors++;
        end
        if (out_dest_index !== exp_r.dest_index) begin
          $error("dest_index expected %h got %h", exp_r.dest_index, out_dest_index);
          errors++;
        end
        if (out_bad_stream !== exp_r.bad_stream) begin
          $error("bad_stream expected %b got %b", exp_r.bad_stream, out_bad_stream);
          errors++;
        end
      end
    end
  end

  // Directed rows under reset settings (16-bit big endian, one stream).
  sample_row_t directed[] = '{
    '{32'h0000_0000, 8'd0, 1'b0, 16'd0,     1'b1, 32'h0000_0000},
    '{32'h0000_FF7F, 8'd0, 1'b1, 16'd65535, 1'b0, 32'h0},
    '{32'h0000_0080, 8'd0, 1'b0, 16'd5,     1'b1, 32'hBF80_0000},
    '{32'h0000_0040, 8'd0, 1'b0, 16'd7,     1'b1, 32'h3F00_0000},
    '{32'hFFFF_FFFF, 8'd0, 1'b0, 16'd1,     1'b0, 32'h0},
    '{32'hABCD_0100, 8'd1, 1'b0, 16'd3,     1'b0, 32'h0},
    '{32'h1234_5678, 8'd255, 1'b1, 16'd9,   1'b0, 32'h0}
  };

  task automatic random_phase(int n);
    logic [7:0] si;
    for (int i = 0; i < n; i++) begin
      si = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(streams_q));
      send_sample($urandom, si, 1'($urandom), 16'($urandom));
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].has_fixed)
        if (predict_sample(directed[i].raw, directed[i].stream, directed[i].side,
                           directed[i].sidx).float_bits !== directed[i].fixed_float) begin
          $error("float_bits expected %h from table", directed[i].fixed_float);
          errors++;
        end
      send_sample(directed[i].raw, directed[i].stream, directed[i].side, directed[i].sidx);
    end
    drain();

    // 24-bit big endian, 32-bit little endian, an unsupported width, coupled streams and zero stride.
    set_config(8'd24, 1'b0, 8'd2, 8'd4, 16'd480);
    send_sample(32'h0000_0080, 8'd1, 1'b1, 16'd0);
    send_sample(32'h00FF_FF7F, 8'd3, 1'b1, 16'd2);
    drain();
    set_config(8'd32, 1'b1, 8'd255, 8'd255, 16'd65535);
    send_sample(32'h8000_0000, 8'd254, 1'b1, 16'd65535);
    send_sample(32'h7FFF_FFFF, 8'd0, 1'b0, 16'd0);
    send_sample(32'h0000_0001, 8'd255, 1'b0, 16'd1);
    drain();
    set_config(8'd8, 1'b0, 8'd5, 8'd2, 16'd0);
    send_sample(32'h0000_0180, 8'd1, 1'b1, 16'd77);
    drain();

    // Random phases: several settings, one with no idling at all.
    for (int ph = 0; ph < 8; ph++) begin
      set_config((ph % 4 == 0) ? 8'($urandom) : ((ph % 4 == 1) ? Width16 :
                 ((ph % 4 == 2) ? Width24 : Width32)),
                 1'($urandom), 8'($urandom_range(ph == 7 ? 255 : 4)),
                 8'($urandom_range(255, 1)), 16'($urandom));
      calm_sender = (ph == 3);
      calm_receiver = (ph == 3);
      random_phase(250);
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
